FILE: rtl/cache_query_request_parser_defines.svh
// Assertion macros used by the checker file.
`ifndef CACHE_QUERY_REQUEST_PARSER_DEFINES_SVH
`define CACHE_QUERY_REQUEST_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CQRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cqrp check failed: label");

// Next-cycle implication, disabled while reset is high.
`define CQRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cqrp check failed: label");

`endif

FILE: rtl/cqrp_pkg.sv
package cqrp_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC0  = 4'd0,
      PH_MAGIC1  = 4'd1,
      PH_VERSION = 4'd2,
      PH_OPCODE  = 4'd3,
      PH_DIGEST  = 4'd4,
      PH_KLEN    = 4'd5,
      PH_KEY     = 4'd6,
      PH_HLEN    = 4'd7,
      PH_HDR     = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      ST_PENDING    = 3'd0,
      ST_HIT        = 3'd1,
      ST_INCOMPLETE = 3'd2,
      ST_MALFORMED  = 3'd3,
      ST_IGNORED    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ROLE_MAGIC    = 4'd0,
      ROLE_VERSION  = 4'd1,
      ROLE_OPCODE   = 4'd2,
      ROLE_DIGEST   = 4'd3,
      ROLE_KEY_LEN  = 4'd4,
      ROLE_KEY      = 4'd5,
      ROLE_HDR_LEN  = 4'd6,
      ROLE_HDR      = 4'd7,
      ROLE_IGNORED  = 4'd8
   } role_type;

   typedef enum logic [2:0] {
      CSR_MAGIC_FIRST  = 3'd0,
      CSR_MAGIC_SECOND = 3'd1,
      CSR_VERSION      = 3'd2,
      CSR_OPCODE       = 3'd3,
      CSR_KEY_CAP      = 3'd4,
      CSR_HDR_CAP      = 3'd5
   } csr_index_type;

   localparam logic [15:0] KEY_CAP_RESET = 16'd129;
   localparam logic [15:0] HDR_CAP_RESET = 16'd1024;

   typedef struct packed {
      logic [7:0]  magic_first;
      logic [7:0]  magic_second;
      logic [7:0]  proto_version;
      logic [7:0]  get_opcode;
      logic [15:0] key_capacity;
      logic [15:0] header_capacity;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      role_type    role;
      logic [15:0] field_offset;
      logic [7:0]  echo_byte;
      logic [15:0] key_length;
      logic [15:0] header_length;
   } result_type;

   function automatic role_type role_of(input phase_type ph);
      role_type r;
      r = ROLE_IGNORED;
      unique case (ph) inside
         PH_MAGIC0, PH_MAGIC1: r = ROLE_MAGIC;
         PH_VERSION:           r = ROLE_VERSION;
         PH_OPCODE:            r = ROLE_OPCODE;
         PH_DIGEST:            r = ROLE_DIGEST;
         PH_KLEN:              r = ROLE_KEY_LEN;
         PH_KEY:               r = ROLE_KEY;
         PH_HLEN:              r = ROLE_HDR_LEN;
         PH_HDR:               r = ROLE_HDR;
         default:              r = ROLE_IGNORED;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/cache_query_request_parser.sv
// Data path: an accepted item goes to the input register, its result to the result
// register that drives rsp_* (the parse runs between the two registers).
// Throughput: one item per cycle; the result register can take a new item in the same
// cycle the waiting one is taken, so the input stalls only while rsp_tready is low.
// Reset (synchronous, active high) empties both registers, rearms the parse state and
// returns the configuration registers to their reset values.
module cache_query_request_parser #(
   parameter int DIGEST_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [18:3] field_offset, [26:19] echo_byte, [42:27] key_length,
   // [58:43] header_length, [63:59] zero
   output logic [63:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // [3:0] byte_role
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import cqrp_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first     <= '0;
         cfg_ff.magic_second    <= '0;
         cfg_ff.proto_version   <= '0;
         cfg_ff.get_opcode      <= '0;
         cfg_ff.key_capacity    <= KEY_CAP_RESET;
         cfg_ff.header_capacity <= HDR_CAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAGIC_FIRST:  cfg_ff.magic_first     <= csr_wdata[7:0];
            CSR_MAGIC_SECOND: cfg_ff.magic_second    <= csr_wdata[7:0];
            CSR_VERSION:      cfg_ff.proto_version   <= csr_wdata[7:0];
            CSR_OPCODE:       cfg_ff.get_opcode      <= csr_wdata[7:0];
            CSR_KEY_CAP:      cfg_ff.key_capacity    <= csr_wdata;
            CSR_HDR_CAP:      cfg_ff.header_capacity <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) in_valid_ff <= 1'b1;
         else if (advance)             in_valid_ff <= 1'b0;
         if (advance)                  out_valid_ff <= 1'b1;
         else if (rsp_tready)          out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) out_ff <= result;
   end

   cqrp_frame_fsm #(
      .DIGEST_BYTES(DIGEST_BYTES)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .end_of_data (in_last_ff),
      .cfg         (cfg_ff),
      .result      (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.role;
   assign rsp_tdata  = {5'd0, out_ff.header_length, out_ff.key_length, out_ff.echo_byte,
                        out_ff.field_offset, out_ff.status};

endmodule

FILE: rtl/cqrp_frame_fsm.sv
module cqrp_frame_fsm #(
   parameter int DIGEST_BYTES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                end_of_data,
   input  cqrp_pkg::cfg_type   cfg,
   output cqrp_pkg::result_type result
);
   import cqrp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] klen_ff, klen_in, klen_upd;
   logic [15:0] hlen_ff, hlen_in, hlen_upd;
   logic [7:0]  low_ff, low_in;
   logic        verdict_ff, verdict_in;

   phase_type   phase_upd;
   logic [15:0] count_upd;
   logic [7:0]  low_upd;
   logic [16:0] count_inc;
   logic [15:0] len_word;
   logic [7:0]  exp_byte;
   logic        verdict_now;
   status_type  status;

   assign count_inc = {1'b0, count_ff} + 17'd1;
   assign len_word  = {data_byte, low_ff};

   always_comb begin
      case (phase_ff)
         PH_MAGIC0:  exp_byte = cfg.magic_first;
         PH_MAGIC1:  exp_byte = cfg.magic_second;
         PH_VERSION: exp_byte = cfg.proto_version;
         default:    exp_byte = cfg.get_opcode;
      endcase
   end

   // next state
   always_comb begin
      phase_upd = phase_ff;
      count_upd = count_ff;
      klen_upd  = klen_ff;
      hlen_upd  = hlen_ff;
      low_upd   = low_ff;
      if (!verdict_ff) begin
         unique case (phase_ff)
            PH_MAGIC0:  if (data_byte == exp_byte) phase_upd = PH_MAGIC1;
            PH_MAGIC1:  if (data_byte == exp_byte) phase_upd = PH_VERSION;
            PH_VERSION: if (data_byte == exp_byte) phase_upd = PH_OPCODE;
            PH_OPCODE: begin
               if (data_byte == exp_byte) begin
                  phase_upd = PH_DIGEST;
                  count_upd = '0;
               end
            end
            PH_DIGEST: begin
               count_upd = count_inc[15:0];
               if (count_inc >= 17'(DIGEST_BYTES)) begin
                  phase_upd = PH_KLEN;
                  count_upd = '0;
               end
            end
            PH_KLEN: begin
               if (count_ff == '0) begin
                  low_upd   = data_byte;
                  count_upd = 16'd1;
               end else begin
                  klen_upd  = len_word;
                  count_upd = '0;
                  if (len_word < cfg.key_capacity)
                     phase_upd = (len_word == '0) ? PH_HLEN : PH_KEY;
               end
            end
            PH_KEY: begin
               count_upd = count_inc[15:0];
               if (count_inc >= {1'b0, klen_ff}) begin
                  phase_upd = PH_HLEN;
                  count_upd = '0;
               end
            end
            PH_HLEN: begin
               if (count_ff == '0) begin
                  low_upd   = data_byte;
                  count_upd = 16'd1;
               end else begin
                  hlen_upd  = len_word;
                  count_upd = '0;
                  if (len_word < cfg.header_capacity && len_word != '0)
                     phase_upd = PH_HDR;
               end
            end
            default: count_upd = count_inc[15:0];
         endcase
      end

      // end of data rearms the parser
      if (end_of_data) begin
         phase_in   = PH_MAGIC0;
         count_in   = '0;
         klen_in    = '0;
         hlen_in    = '0;
         low_in     = '0;
         verdict_in = 1'b0;
      end else begin
         phase_in   = phase_upd;
         count_in   = count_upd;
         klen_in    = klen_upd;
         hlen_in    = hlen_upd;
         low_in     = low_upd;
         verdict_in = verdict_ff | verdict_now;
      end
   end

   // outputs
   always_comb begin
      status      = ST_PENDING;
      verdict_now = 1'b0;
      if (verdict_ff) begin
         status = ST_IGNORED;
      end else begin
         unique case (phase_ff)
            PH_MAGIC0, PH_MAGIC1, PH_VERSION, PH_OPCODE: begin
               if (data_byte != exp_byte) status = ST_MALFORMED;
            end
            PH_KLEN: begin
               if (count_ff != '0 && len_word >= cfg.key_capacity) status = ST_MALFORMED;
            end
            PH_HLEN: begin
               if (count_ff != '0) begin
                  if (len_word >= cfg.header_capacity) status = ST_MALFORMED;
                  else if (len_word == '0)             status = ST_HIT;
               end
            end
            PH_HDR: begin
               if (count_inc >= {1'b0, hlen_ff}) status = ST_HIT;
            end
            default: status = ST_PENDING;
         endcase
         verdict_now = (status == ST_MALFORMED) || (status == ST_HIT);
         if (!verdict_now && end_of_data) status = ST_INCOMPLETE;
      end

      result.status        = status;
      result.role          = verdict_ff ? ROLE_IGNORED : role_of(phase_ff);
      result.field_offset  = verdict_ff ? 16'd0 : count_ff;
      result.echo_byte     = data_byte;
      result.key_length    = klen_upd;
      result.header_length = hlen_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC0;
         count_ff   <= '0;
         klen_ff    <= '0;
         hlen_ff    <= '0;
         low_ff     <= '0;
         verdict_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         klen_ff    <= klen_in;
         hlen_ff    <= hlen_in;
         low_ff     <= low_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

FILE: rtl/cqrp_checker.sv
`include "cache_query_request_parser_defines.svh"

module cqrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);
   import cqrp_pkg::*;

   logic [2:0] st;
   assign st = rsp_tdata[2:0];

   `CQRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `CQRP_ASSERT_NOW(a_ignored_form, clock, reset, rsp_tvalid && st == ST_IGNORED, rsp_tuser == ROLE_IGNORED && rsp_tdata[18:3] == 16'd0)
   `CQRP_ASSERT_NOW(a_active_role, clock, reset, rsp_tvalid && st != ST_IGNORED, rsp_tuser != ROLE_IGNORED)
   `CQRP_ASSERT_NOW(a_hit_role, clock, reset, rsp_tvalid && st == ST_HIT, rsp_tuser == ROLE_HDR_LEN || rsp_tuser == ROLE_HDR)

endmodule

bind cache_query_request_parser cqrp_checker u_cqrp_checker (.*);

FILE: verif/cache_query_request_parser_tb.sv
`timescale 1ns / 100ps

module cache_query_request_parser_tb;
   import cqrp_pkg::*;

   localparam int DIGEST_LEN  = 32;
   localparam int CLK_HALF    = 10;
   localparam int RESET_LEN   = 5;
   localparam int DRAIN_SLACK = 4;
   localparam int HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // end_of_data
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [2:0] status, [18:3] field_offset, [26:19] echo_byte, [42:27] key_length,
   // [58:43] header_length, [63:59] zero
   logic [63:0] rsp_tdata;
   logic [3:0]  rsp_tuser;   // [3:0] byte_role
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   cache_query_request_parser #(.DIGEST_BYTES(DIGEST_LEN)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // parser shadow: configuration and frame walk state
   cfg_type     cfg_model;
   phase_type   parse_phase;
   logic [15:0] field_pos;
   logic [15:0] key_len_seen;
   logic [15:0] hdr_len_seen;
   logic [7:0]  low_len_byte;
   bit          verdict_seen;

   result_type  parse_results_due[$];
   int          error_count;
   int          live_items;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_requests;
   int          hold_granted;
   int          hold_left;

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void clear_parse();
      parse_phase  = PH_MAGIC0;
      field_pos    = '0;
      key_len_seen = '0;
      hdr_len_seen = '0;
      low_len_byte = '0;
      verdict_seen = 1'b0;
   endfunction

   // Walks the frame one byte and returns what the parser must report for it.
   function automatic result_type predict_parse(input logic [7:0] b, input logic eod);
      result_type r;
      r.status       = ST_PENDING;
      r.role         = ROLE_IGNORED;
      r.field_offset = '0;
      r.echo_byte    = b;
      if (verdict_seen) begin
         r.status = ST_IGNORED;
      end else begin
         r.field_offset = field_pos;
         case (parse_phase)
            PH_MAGIC0: begin
               r.role = ROLE_MAGIC;
               if (b != cfg_model.magic_first) r.status = ST_MALFORMED;
               else parse_phase = PH_MAGIC1;
            end
            PH_MAGIC1: begin
               r.role = ROLE_MAGIC;
               if (b != cfg_model.magic_second) r.status = ST_MALFORMED;
               else parse_phase = PH_VERSION;
            end
            PH_VERSION: begin
               r.role = ROLE_VERSION;
               if (b != cfg_model.proto_version) r.status = ST_MALFORMED;
               else parse_phase = PH_OPCODE;
            end
            PH_OPCODE: begin
               r.role = ROLE_OPCODE;
               if (b != cfg_model.get_opcode) begin
                  r.status = ST_MALFORMED;
               end else begin
                  parse_phase = PH_DIGEST;
                  field_pos   = '0;
               end
            end
            PH_DIGEST: begin
               r.role = ROLE_DIGEST;
               field_pos++;
               if (field_pos >= DIGEST_LEN) begin
                  parse_phase = PH_KLEN;
                  field_pos   = '0;
               end
            end
            PH_KLEN: begin
               r.role = ROLE_KEY_LEN;
               if (field_pos == 0) begin
                  low_len_byte = b;
                  field_pos    = 16'd1;
               end else begin
                  key_len_seen = {b, low_len_byte};
                  field_pos    = '0;
                  if (key_len_seen >= cfg_model.key_capacity) r.status = ST_MALFORMED;
                  else if (key_len_seen == 0) parse_phase = PH_HLEN;
                  else parse_phase = PH_KEY;
               end
            end
            PH_KEY: begin
               r.role = ROLE_KEY;
               field_pos++;
               if (field_pos >= key_len_seen) begin
                  parse_phase = PH_HLEN;
                  field_pos   = '0;
               end
            end
            PH_HLEN: begin
               r.role = ROLE_HDR_LEN;
               if (field_pos == 0) begin
                  low_len_byte = b;
                  field_pos    = 16'd1;
               end else begin
                  hdr_len_seen = {b, low_len_byte};
                  field_pos    = '0;
                  if (hdr_len_seen >= cfg_model.header_capacity) r.status = ST_MALFORMED;
                  else if (hdr_len_seen == 0) r.status = ST_HIT;
                  else parse_phase = PH_HDR;
               end
            end
            default: begin
               r.role = ROLE_HDR;
               field_pos++;
               if (field_pos >= hdr_len_seen) r.status = ST_HIT;
            end
         endcase
         if (r.status == ST_MALFORMED || r.status == ST_HIT) verdict_seen = 1'b1;
         else if (eod) r.status = ST_INCOMPLETE;
      end
      r.key_length    = key_len_seen;
      r.header_length = hdr_len_seen;
      if (eod) clear_parse();
      return r;
   endfunction

   // Offers one byte, waits for the handshake, then books its expected result.
   task automatic send_byte(input logic [7:0] b, input logic eod);
      result_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eod;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_parse(b, eod);
      if (r.status != ST_IGNORED) live_items++;
      parse_results_due.push_back(r);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (parse_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic program_parser(input logic [7:0] m0, input logic [7:0] m1,
                                 input logic [7:0] ver, input logic [7:0] op,
                                 input logic [15:0] kcap, input logic [15:0] hcap);
      logic [15:0] vals [6];
      csr_index_type idx;
      vals[CSR_MAGIC_FIRST]  = {8'h00, m0};
      vals[CSR_MAGIC_SECOND] = {8'h00, m1};
      vals[CSR_VERSION]      = {8'h00, ver};
      vals[CSR_OPCODE]       = {8'h00, op};
      vals[CSR_KEY_CAP]      = kcap;
      vals[CSR_HDR_CAP]      = hcap;
      wait_drain();
      for (int i = 0; i < 6; i++) begin
         idx = csr_index_type'(i);
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         case (idx)
            CSR_MAGIC_FIRST:  cfg_model.magic_first     = vals[i][7:0];
            CSR_MAGIC_SECOND: cfg_model.magic_second    = vals[i][7:0];
            CSR_VERSION:      cfg_model.proto_version   = vals[i][7:0];
            CSR_OPCODE:       cfg_model.get_opcode      = vals[i][7:0];
            CSR_KEY_CAP:      cfg_model.key_capacity    = vals[i];
            default:          cfg_model.header_capacity = vals[i];
         endcase
      end
      csr_wr_en <= 1'b0;
   endtask

   // Builds a query frame from the current setting; eod goes on the last byte sent.
   // cut > 0 truncates it, corrupt_at >= 0 flips bits in one byte.
   task automatic send_query_frame(input int key_len, input int hdr_len, input int cut,
                                   input int corrupt_at, input int trailing);
      logic [7:0] fb[$];
      int key_bytes;
      int hdr_bytes;
      // past a bad length only a few bytes are sent; they are ignored anyway
      key_bytes = (key_len >= cfg_model.key_capacity) ? ((key_len < 4) ? key_len : 4)
                                                       : key_len;
      hdr_bytes = (hdr_len >= cfg_model.header_capacity) ? ((hdr_len < 4) ? hdr_len : 4)
                                                          : hdr_len;
      fb.push_back(cfg_model.magic_first);
      fb.push_back(cfg_model.magic_second);
      fb.push_back(cfg_model.proto_version);
      fb.push_back(cfg_model.get_opcode);
      repeat (DIGEST_LEN) fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(key_len[7:0]);
      fb.push_back(key_len[15:8]);
      repeat (key_bytes) fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(hdr_len[7:0]);
      fb.push_back(hdr_len[15:8]);
      repeat (hdr_bytes) fb.push_back(8'($urandom_range(0, 255)));
      if (corrupt_at >= 0 && corrupt_at < fb.size())
         fb[corrupt_at] = fb[corrupt_at] ^ 8'($urandom_range(1, 255));
      if (cut > 0)
         while (fb.size() > cut) void'(fb.pop_back());
      repeat (trailing) fb.push_back(8'($urandom_range(0, 255)));
      foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++)
         send_byte(8'($urandom_range(0, 255)),
                   (i == count - 1) || ($urandom_range(0, 5) == 0));
   endtask

   // Mostly legal lengths, weighted small; sometimes at or past capacity.
   function automatic int pick_length(input int cap);
      int r;
      int top;
      r = $urandom_range(0, 99);
      if (r < 3) return 65535;
      if (cap == 0 || r < 12)
         return cap + $urandom_range(0, (cap > 65532) ? 65535 - cap : 3);
      top = (cap - 1 > 300) ? 300 : cap - 1;
      if (r < 18) return $urandom_range(0, top);
      return $urandom_range(0, (top > 12) ? 12 : top);
   endfunction

   function automatic int pick_capacity(input int dflt);
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return 0;
      if (r < 12) return 1;
      if (r < 22) return 65535;
      if (r < 40) return dflt;
      return $urandom_range(2, 300);
   endfunction

   function automatic logic [7:0] pick_fixed_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 8'h00;
      if (r < 30) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic program_random_setting();
      program_parser(pick_fixed_byte(), pick_fixed_byte(), pick_fixed_byte(),
                     pick_fixed_byte(), 16'(pick_capacity(KEY_CAP_RESET)),
                     16'(pick_capacity(HDR_CAP_RESET)));
   endtask

   // Result side: checks each item taken and drives tready with random stalls.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (parse_results_due.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata[15:0], '0);
         end else begin
            want = parse_results_due.pop_front();
            if (rsp_tdata[2:0] !== want.status)
               report_mismatch("status", 16'(rsp_tdata[2:0]), 16'(want.status));
            if (rsp_tuser !== want.role)
               report_mismatch("byte_role", 16'(rsp_tuser), 16'(want.role));
            if (rsp_tdata[18:3] !== want.field_offset)
               report_mismatch("field_offset", rsp_tdata[18:3], want.field_offset);
            if (rsp_tdata[26:19] !== want.echo_byte)
               report_mismatch("echo_byte", 16'(rsp_tdata[26:19]), 16'(want.echo_byte));
            if (rsp_tdata[42:27] !== want.key_length)
               report_mismatch("key_length", rsp_tdata[42:27], want.key_length);
            if (rsp_tdata[58:43] !== want.header_length)
               report_mismatch("header_length", rsp_tdata[58:43], want.header_length);
            if (rsp_tdata[63:59] !== 5'd0)
               report_mismatch("tdata pad", 16'(rsp_tdata[63:59]), '0);
         end
      end
      if (hold_requests != hold_granted) begin
         hold_granted = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Reset setting: all fixed bytes zero.
   task automatic test_directed();
      send_byte(8'hFF, 1'b0);   // bad first magic
      send_byte(8'h00, 1'b0);   // ignored after verdict
      send_byte(8'h5A, 1'b1);   // ignored, eod still rearms
      send_byte(8'h00, 1'b1);   // incomplete on first byte
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);   // malformed beats incomplete
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b1);   // bad version
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);   // bad opcode
      send_query_frame(0, 0, 0, -1, 0);          // both lengths zero, hit on eod byte
      send_query_frame(KEY_CAP_RESET, 0, 0, -1, 2);
   endtask

   task automatic test_random_frames(input int live_goal);
      int start;
      int last_setting;
      int r;
      int klen;
      int hlen;
      start        = live_items;
      last_setting = live_items;
      program_random_setting();
      while (live_items - start < live_goal) begin
         if (live_items - last_setting > 150) begin
            program_random_setting();
            last_setting = live_items;
         end
         r    = $urandom_range(0, 99);
         klen = pick_length(cfg_model.key_capacity);
         hlen = pick_length(cfg_model.header_capacity);
         if (r < 55)
            send_query_frame(klen, hlen, 0, -1,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
         else if (r < 70)
            send_query_frame(klen, hlen, 0,
                             $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 40), 0);
         else if (r < 85)
            send_query_frame(klen, hlen, $urandom_range(1, 45), -1, 0);
         else
            send_noise($urandom_range(1, 10));
      end
   endtask

   // Output held off while a whole frame is offered; input must stall and recover.
   task automatic test_backpressure();
      int saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      program_parser(8'hA5, 8'h5A, 8'h02, 8'h01, 16'd16, 16'd32);
      hold_requests++;
      send_query_frame(4, 6, 0, -1, 0);
      wait_drain();
      send_query_frame(3, 2, 0, -1, 1);
      send_idle_pct = saved_idle;
   endtask

   task automatic test_capacity_limits();
      // zero capacity rejects even a zero length
      program_parser(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd0);
      send_query_frame(0, 0, 0, -1, 1);
      program_parser(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd1, 16'd0);
      send_query_frame(0, 0, 0, -1, 0);
      program_parser(8'h7E, 8'h81, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
      send_query_frame(65535, 0, 0, -1, 0);
      send_query_frame(0, 65535, 0, -1, 0);
      send_query_frame(65534, 3, 60, -1, 0);
      send_query_frame(3, 2, 0, -1, 0);
      program_parser(8'h00, 8'h00, 8'h00, 8'h00, KEY_CAP_RESET, HDR_CAP_RESET);
      send_query_frame(KEY_CAP_RESET - 1, 1, 0, -1, 0);
      send_query_frame(1, HDR_CAP_RESET, 0, -1, 0);
   endtask

   initial begin
      error_count   = 0;
      live_items    = 0;
      cycle_count   = 0;
      hold_requests = 0;
      hold_granted  = 0;
      hold_left     = 0;
      send_idle_pct = 14;
      recv_idle_pct = 80;
      cfg_model.magic_first     = 8'h00;
      cfg_model.magic_second    = 8'h00;
      cfg_model.proto_version   = 8'h00;
      cfg_model.get_opcode      = 8'h00;
      cfg_model.key_capacity    = KEY_CAP_RESET;
      cfg_model.header_capacity = HDR_CAP_RESET;
      clear_parse();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= 3'd0;
      csr_wdata  <= 16'h0000;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_frames(220);
      test_backpressure();

      send_idle_pct = 80;
      recv_idle_pct = 14;
      test_capacity_limits();
      test_random_frames(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(180);

      wait_drain();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
